[src/ict_pkg.sv]
// Shared constants, types and codes for the inode cache table.
package ict_pkg;

    localparam int TABLE_ENTRIES    = 64;
    localparam int IDX_W            = $clog2(TABLE_ENTRIES);
    localparam int BLK_INODE_SLOTS  = 8;
    localparam int OFF_W            = $clog2(BLK_INODE_SLOTS);

    localparam int DEV_W      = 8;
    localparam int INO_W      = 32;
    localparam int SLOT_W     = 6;
    localparam int REFS_W     = 16;
    localparam int BLK_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int ENT_IDX_W  = 6;
    localparam int CFG_W      = 32;

    typedef logic [IDX_W-1:0] idx_t;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT       = 3'd0,
        ST_ALLOC     = 3'd1,
        ST_FULL      = 3'd2,
        ST_RELEASED  = 3'd3,
        ST_HELD      = 3'd4,
        ST_UNDERFLOW = 3'd5
    } status_t;

    typedef struct packed {
        logic [DEV_W-1:0]  device;
        logic [INO_W-1:0]  inode;
        logic [REFS_W-1:0] refs;
    } entry_t;

    typedef struct packed {
        logic              req_type;
        logic [DEV_W-1:0]  device;
        logic [INO_W-1:0]  inode_number;
        logic [SLOT_W-1:0] slot;
    } req_item_t;

    typedef struct packed {
        status_t              status;
        logic [ENT_IDX_W-1:0] entry_index;
        logic [REFS_W-1:0]    ref_count;
        logic [BLK_W-1:0]     load_block;
        logic [OFF_W-1:0]     load_offset;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_GET_WB,
        S_PUT_WB,
        S_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic get_wb;
        logic put_wb;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_match;
        logic scan_last;
    } dp_status_t;

endpackage

[src/ict_if.sv]
// Valid/ready channel interfaces for requests and responses.
interface ict_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [ict_pkg::DEV_W-1:0]   device;
    logic [ict_pkg::INO_W-1:0]   inode_number;
    logic [ict_pkg::SLOT_W-1:0]  slot;

    modport source (output valid, output req_type, output device, output inode_number,
                    output slot, input ready);
    modport sink   (input valid, input req_type, input device, input inode_number,
                    input slot, output ready);
endinterface

interface ict_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ict_pkg::STATUS_W-1:0]  status;
    logic [ict_pkg::ENT_IDX_W-1:0] entry_index;
    logic [ict_pkg::REFS_W-1:0]    ref_count;
    logic [ict_pkg::BLK_W-1:0]     load_block;
    logic [ict_pkg::OFF_W-1:0]     load_offset;

    modport source (output valid, output status, output entry_index, output ref_count,
                    output load_block, output load_offset, input ready);
    modport sink   (input valid, input status, input entry_index, input ref_count,
                    input load_block, input load_offset, output ready);
endinterface

[src/ict_ctrl.sv]
// Control state machine: sequences scan, write-back and response hand-off.
module ict_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_type,
    output logic                   in_ready,
    input  logic                   out_ready,
    output logic                   out_valid,
    input  ict_pkg::dp_status_t    stat,
    output ict_pkg::ctrl_cmd_t     cmd
);
    import ict_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_type == REQ_PUT) ? S_PUT_WB : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_match || stat.scan_last)
                begin
                    state_next = S_GET_WB;
                end
            end
            S_GET_WB: state_next = S_EMIT;
            S_PUT_WB: state_next = S_EMIT;
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_SCAN:   cmd.scan   = 1'b1;
            S_GET_WB: cmd.get_wb = 1'b1;
            S_PUT_WB: cmd.put_wb = 1'b1;
            S_EMIT:   cmd.out_load = !out_valid_reg || out_ready;
            default:  cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[src/ict_dpath.sv]
// Datapath: entry memory with valid bits, scan bookkeeping, result and output registers.
module ict_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ict_pkg::ctrl_cmd_t          cmd,
    output ict_pkg::dp_status_t         stat,
    input  ict_pkg::req_item_t          req_in,
    input  logic                        cfg_wr_en,
    input  logic [ict_pkg::CFG_W-1:0]   cfg_wr_data,
    output ict_pkg::rsp_item_t          rsp_out
);
    import ict_pkg::*;

    entry_t                   mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    entry_t                   rd_data_reg;
    logic                     rd_vld_reg;
    idx_t                     rd_idx_reg, rd_addr;

    req_item_t                req_reg;
    logic [CFG_W-1:0]         start_reg;

    logic                     hit_reg, hit_next;
    logic                     found_reg, found_next;
    idx_t                     sel_idx_reg, sel_idx_next;
    logic [REFS_W-1:0]        sel_refs_reg, sel_refs_next;

    rsp_item_t                res_reg, res_next;
    rsp_item_t                out_reg;

    logic                     wr_en;
    idx_t                     wr_addr;
    entry_t                   wr_data;
    entry_t                   ent;
    logic [INO_W-1:0]         rel;
    logic [REFS_W-1:0]        refs_inc, refs_dec;
    logic                     slot_ok;

    // never-written entries read as the cleared value
    assign ent = rd_vld_reg ? rd_data_reg : '0;

    assign stat.scan_match = (ent.device == req_reg.device) &&
                             (ent.inode == req_reg.inode_number);
    assign stat.scan_last  = (rd_idx_reg == idx_t'(TABLE_ENTRIES - 1));

    assign slot_ok  = (32'(req_reg.slot) < 32'(TABLE_ENTRIES));
    assign rel      = req_reg.inode_number - INO_W'(1);
    assign refs_inc = (sel_refs_reg == '1) ? sel_refs_reg : sel_refs_reg + REFS_W'(1);
    assign refs_dec = ent.refs - REFS_W'(1);

    always_comb
    begin
        if (cmd.capture)
        begin
            rd_addr = (req_in.req_type == REQ_PUT) ? idx_t'(req_in.slot) : '0;
        end
        else
        begin
            rd_addr = rd_idx_reg + idx_t'(1);
        end
    end

    // scan bookkeeping: first match wins, else remember lowest free slot
    always_comb
    begin
        hit_next      = hit_reg;
        found_next    = found_reg;
        sel_idx_next  = sel_idx_reg;
        sel_refs_next = sel_refs_reg;
        if (cmd.capture)
        begin
            hit_next   = 1'b0;
            found_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            if (stat.scan_match)
            begin
                hit_next      = 1'b1;
                sel_idx_next  = rd_idx_reg;
                sel_refs_next = ent.refs;
            end
            else if (ent.refs == '0 && !found_reg)
            begin
                found_next   = 1'b1;
                sel_idx_next = rd_idx_reg;
            end
        end
    end

    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = sel_idx_reg;
        wr_data  = '0;
        res_next = res_reg;
        if (cmd.get_wb)
        begin
            res_next.load_block  = '0;
            res_next.load_offset = '0;
            if (hit_reg)
            begin
                wr_en                = 1'b1;
                wr_data.device       = req_reg.device;
                wr_data.inode        = req_reg.inode_number;
                wr_data.refs         = refs_inc;
                res_next.status      = ST_HIT;
                res_next.entry_index = ENT_IDX_W'(sel_idx_reg);
                res_next.ref_count   = refs_inc;
            end
            else if (found_reg)
            begin
                wr_en                = 1'b1;
                wr_data.device       = req_reg.device;
                wr_data.inode        = req_reg.inode_number;
                wr_data.refs         = REFS_W'(1);
                res_next.status      = ST_ALLOC;
                res_next.entry_index = ENT_IDX_W'(sel_idx_reg);
                res_next.ref_count   = REFS_W'(1);
                res_next.load_block  = BLK_W'(rel >> OFF_W) + start_reg;
                res_next.load_offset = rel[OFF_W-1:0];
            end
            else
            begin
                res_next.status      = ST_FULL;
                res_next.entry_index = '0;
                res_next.ref_count   = '0;
            end
        end
        else if (cmd.put_wb)
        begin
            res_next.entry_index = ENT_IDX_W'(req_reg.slot);
            res_next.load_block  = '0;
            res_next.load_offset = '0;
            if (slot_ok && ent.refs != '0)
            begin
                wr_en              = 1'b1;
                wr_addr            = rd_idx_reg;
                wr_data.device     = ent.device;
                wr_data.inode      = ent.inode;
                wr_data.refs       = refs_dec;
                res_next.status    = (refs_dec == '0) ? ST_RELEASED : ST_HELD;
                res_next.ref_count = refs_dec;
            end
            else
            begin
                res_next.status    = ST_UNDERFLOW;
                res_next.ref_count = '0;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
            start_reg  <= '0;
            hit_reg    <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            rd_vld_reg <= valid_reg[rd_addr];
            if (cmd.capture || cmd.scan)
            begin
                rd_idx_reg <= rd_addr;
            end
            if (cfg_wr_en)
            begin
                start_reg <= cfg_wr_data;
            end
            hit_reg    <= hit_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_in;
        end
        sel_idx_reg  <= sel_idx_next;
        sel_refs_reg <= sel_refs_next;
        res_reg      <= res_next;
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign rsp_out = out_reg;

endmodule

[src/inode_cache_table_core.sv]
// Top level of the reference-counted inode cache table.
// One request is taken at a time. A get scans the entry table one entry per
// cycle through the single read port of the entry memory, stopping at the
// first matching entry or after the last entry on a miss; a put reads its
// slot directly. The finished result sits in an output register and is held
// until the response transaction completes; the next request is accepted
// while it waits. Entries are cleared at reset through per-entry valid bits,
// so no clearing pass is needed and the block is ready right after reset.
// The table start register may be written only while no request is in flight.
module inode_cache_table_core (
    input  logic                      clk,
    input  logic                      rst_n,
    ict_req_if.sink                   req,
    ict_rsp_if.source                 rsp,
    input  logic                      cfg_wr_en,
    input  logic [ict_pkg::CFG_W-1:0] cfg_wr_data
);
    import ict_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;
    req_item_t  req_item;
    rsp_item_t  rsp_item;

    assign req_item.req_type     = req.req_type;
    assign req_item.device       = req.device;
    assign req_item.inode_number = req.inode_number;
    assign req_item.slot         = req.slot;

    ict_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_type   (req.req_type),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    ict_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_in      (req_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rsp_out     (rsp_item)
    );

    assign rsp.status      = rsp_item.status;
    assign rsp.entry_index = rsp_item.entry_index;
    assign rsp.ref_count   = rsp_item.ref_count;
    assign rsp.load_block  = rsp_item.load_block;
    assign rsp.load_offset = rsp_item.load_offset;

endmodule
